### rtl/core/rlm_pkg.sv
// ----------------------------------------------------------------------------
// Radial lens distortion map package
// Widths, fixed-point constants, register indexes and the pipeline word
// types shared by the front end, the root solver cells and the back end.
// ----------------------------------------------------------------------------
package rlm_pkg;

	// Coordinate format: signed, INT_BITS integer and FRAC_BITS fraction bits.
	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 11;
	localparam int CW        = INT_BITS + FRAC_BITS + 1;

	// Offset from the axis (doubled in summation mode) and its magnitude.
	localparam int OW  = CW + 2;
	localparam int MW  = CW + 1;
	localparam int SQW = 2 * MW;
	localparam int S2W = SQW + 1;

	// Distortion constant K in units of 2^-60, split as 2^32 + K_LO.
	localparam int          K_BITS = 32;
	localparam logic [31:0] K_LO   = 32'd3291256204;
	localparam int          G_SHIFT = 2 * FRAC_BITS + 20;
	localparam int          PW      = S2W + K_BITS + 1;
	localparam int          GW      = PW - G_SHIFT;
	localparam int          S2_LO   = S2W / 2;
	localparam int          S2_HI   = S2W - S2_LO;

	// K*R^2 carries 40 fraction bits; the scale factor q carries 32.
	localparam int G_FRAC = 40;
	localparam int Q_BITS = 32;
	localparam int QIW    = $clog2(Q_BITS);
	localparam int GLW    = Q_BITS;
	localparam int GHW    = GW - GLW;
	// Below this value of K*R^2 the undistort scale is exactly one.
	localparam int QONE_BITS = G_FRAC - Q_BITS;

	// Mapped value before the axis is added back, and after.
	localparam int NW = OW + 1;
	localparam int TW = NW + 2;

	// Configuration register indexes.
	localparam int CIW = 2;
	localparam logic [CIW-1:0] REG_SUMMATION   = 2'd0;
	localparam logic [CIW-1:0] REG_AXIS_LINE   = 2'd1;
	localparam logic [CIW-1:0] REG_AXIS_SAMPLE = 2'd2;
	localparam int AXW = 10;
	localparam logic [AXW-1:0] AXIS_RESET = 10'd400;

	// Word that travels down the pipeline for one coordinate pair.
	typedef struct packed {
		logic                 cmd;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] x;
		logic [GW-1:0]        g;
		logic                 qone;
	} item_t;

	// Partial root: scale factor so far and its exact square.
	typedef struct packed {
		logic [Q_BITS-1:0]   q;
		logic [2*Q_BITS-1:0] q2;
	} solve_t;

endpackage

### rtl/core/rlm_front.sv
// ----------------------------------------------------------------------------
// Radial lens distortion map front end
// Moves the point to an axis offset and computes K*R^2 in six stages.
// ----------------------------------------------------------------------------
module rlm_front import rlm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 cmd,
	input  logic signed [CW-1:0] line_in,
	input  logic signed [CW-1:0] sample_in,
	input  logic                 summation_mode,
	input  logic [AXW-1:0]       axis_line,
	input  logic [AXW-1:0]       axis_sample,
	output logic                 out_valid,
	output item_t                out_item
);

	logic [6:1] vld_q;

	logic                 cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic signed [OW-1:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	logic signed [OW-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [MW-1:0]        ay_s2, ax_s2;
	logic [SQW-1:0]       sqy_s3, sqx_s3;
	logic [S2W-1:0]       s2_s4, s2_s5;
	logic [S2_LO+K_BITS-1:0] pl_s5;
	logic [S2_HI+K_BITS-1:0] ph_s5;
	item_t                item_s6;

	logic signed [OW-1:0] l_ext, s_ext, a_l, a_s, y_c, x_c;
	logic [OW-1:0]        ny_c, nx_c;
	logic [PW-1:0]        tot_c;
	logic [GW-1:0]        g_c;

	// Stage 1: offsets from the axis, doubled first in summation mode.
	assign l_ext = OW'(line_in);
	assign s_ext = OW'(sample_in);
	assign a_l   = signed'(OW'({axis_line, FRAC_BITS'(0)}));
	assign a_s   = signed'(OW'({axis_sample, FRAC_BITS'(0)}));
	assign y_c   = summation_mode ? (l_ext <<< 1) - a_l : l_ext - a_l;
	assign x_c   = summation_mode ? (s_ext <<< 1) - a_s : s_ext - a_s;

	// Stage 2 magnitudes.
	assign ny_c = -y_s1;
	assign nx_c = -x_s1;

	// Stage 6: K*R^2 = (s2 * 2^32 + s2 * K_LO) >> G_SHIFT.
	assign tot_c = (PW'(s2_s5) << K_BITS) + (PW'(ph_s5) << S2_LO) + PW'(pl_s5);
	assign g_c   = tot_c[G_SHIFT +: GW];

	// Valid bits of the six stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:1], in_valid};
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		y_s1   <= y_c;
		x_s1   <= x_c;

		cmd_s2 <= cmd_s1;
		y_s2   <= y_s1;
		x_s2   <= x_s1;
		ay_s2  <= y_s1[OW-1] ? ny_c[MW-1:0] : y_s1[MW-1:0];
		ax_s2  <= x_s1[OW-1] ? nx_c[MW-1:0] : x_s1[MW-1:0];

		cmd_s3 <= cmd_s2;
		y_s3   <= y_s2;
		x_s3   <= x_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		sqx_s3 <= ax_s2 * ax_s2;

		cmd_s4 <= cmd_s3;
		y_s4   <= y_s3;
		x_s4   <= x_s3;
		s2_s4  <= S2W'(sqy_s3) + S2W'(sqx_s3);

		cmd_s5 <= cmd_s4;
		y_s5   <= y_s4;
		x_s5   <= x_s4;
		s2_s5  <= s2_s4;
		pl_s5  <= s2_s4[S2_LO-1:0] * K_LO;
		ph_s5  <= s2_s4[S2W-1:S2_LO] * K_LO;

		item_s6.cmd  <= cmd_s5;
		item_s6.y    <= y_s5;
		item_s6.x    <= x_s5;
		item_s6.g    <= g_c;
		item_s6.qone <= ~|g_c[GW-1:QONE_BITS];
	end

	assign out_valid = vld_q[6];
	assign out_item  = item_s6;

endmodule

### rtl/core/rlm_cell.sv
// ----------------------------------------------------------------------------
// Radial lens distortion map root cell
// Decides one bit of the undistort scale q: keeps the trial bit when
// q + K*R^2*q^3 stays within one. Four stages per cell.
// ----------------------------------------------------------------------------
module rlm_cell import rlm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [QIW-1:0] bit_idx,
	input  logic           in_valid,
	input  item_t          in_item,
	input  solve_t         in_sol,
	output logic           out_valid,
	output item_t          out_item,
	output solve_t         out_sol
);

	logic [4:1] vld_q;

	item_t               item_s1, item_s2, item_s3, item_s4;
	solve_t              sol_s1, sol_s2, sol_s3, sol_s4;
	logic [Q_BITS-1:0]   c_s1, c_s2, c_s3;
	logic [2*Q_BITS-1:0] c2_s1, c2_s2, c2_s3;
	logic [2*Q_BITS-1:0] m1_s2;
	logic [Q_BITS+GLW-1:0] mlo_s3;
	logic [Q_BITS+GHW-1:0] mhi_s3;

	logic [Q_BITS-1:0]   c_c;
	logic [2*Q_BITS-1:0] c2_c;
	logic [QIW:0]        sh1_c, sh2_c;
	logic [Q_BITS+GW:0]  t_c;
	logic [Q_BITS:0]     t3_c;
	logic                fits_c;

	// Trial value and its exact square, built from the previous square.
	assign sh1_c = {1'b0, bit_idx} + (QIW+1)'(1);
	assign sh2_c = {bit_idx, 1'b0};
	assign c_c   = in_sol.q | (Q_BITS'(1) << bit_idx);
	assign c2_c  = in_sol.q2 + ((2*Q_BITS)'(in_sol.q) << sh1_c)
		+ ((2*Q_BITS)'(1) << sh2_c);

	// Cubic term and the bound check.
	assign t_c    = ((Q_BITS+GW+1)'(mhi_s3) << GLW) + (Q_BITS+GW+1)'(mlo_s3);
	assign t3_c   = t_c[G_FRAC +: Q_BITS+1];
	assign fits_c = ((Q_BITS+2)'(c_s3) + (Q_BITS+2)'(t3_c)) <= ((Q_BITS+2)'(1) << Q_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		sol_s1  <= in_sol;
		c_s1    <= c_c;
		c2_s1   <= c2_c;

		item_s2 <= item_s1;
		sol_s2  <= sol_s1;
		c_s2    <= c_s1;
		c2_s2   <= c2_s1;
		m1_s2   <= c2_s1[2*Q_BITS-1:Q_BITS] * c_s1;

		item_s3 <= item_s2;
		sol_s3  <= sol_s2;
		c_s3    <= c_s2;
		c2_s3   <= c2_s2;
		mlo_s3  <= m1_s2[2*Q_BITS-1:Q_BITS] * item_s2.g[GLW-1:0];
		mhi_s3  <= m1_s2[2*Q_BITS-1:Q_BITS] * item_s2.g[GW-1:GLW];

		item_s4 <= item_s3;
		if (fits_c) begin
			sol_s4.q  <= c_s3;
			sol_s4.q2 <= c2_s3;
		end else begin
			sol_s4 <= sol_s3;
		end
	end

	assign out_valid = vld_q[4];
	assign out_item  = item_s4;
	assign out_sol   = sol_s4;

endmodule

### rtl/core/rlm_back.sv
// ----------------------------------------------------------------------------
// Radial lens distortion map back end
// Scales the offsets, adds the axis back, halves in summation mode and
// saturates. Four stages; the last one drives the result ports.
// ----------------------------------------------------------------------------
module rlm_back import rlm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  item_t                in_item,
	input  logic [Q_BITS-1:0]    in_q,
	input  logic                 summation_mode,
	input  logic [AXW-1:0]       axis_line,
	input  logic [AXW-1:0]       axis_sample,
	output logic                 out_valid,
	output logic signed [CW-1:0] line_out,
	output logic signed [CW-1:0] sample_out,
	output logic                 clipped
);

	localparam int DW = MW + GW + 1;
	localparam int UW = MW + Q_BITS + 1;
	localparam logic signed [TW-1:0] T_MAX = TW'((64'(1) << (CW-1)) - 64'(1));
	localparam logic signed [TW-1:0] T_MIN = -T_MAX - TW'(1);

	logic [4:1] vld_q;

	item_t             item_s1, item_s2;
	logic [Q_BITS-1:0] q_s1;
	logic [MW-1:0]     ay_s1, ax_s1;
	logic [MW+GLW-1:0] dyl_s2, dxl_s2;
	logic [MW+GHW-1:0] dyh_s2, dxh_s2;
	logic [MW+Q_BITS-1:0] uy_s2, ux_s2;
	logic signed [NW-1:0] ny_s3, nx_s3;
	logic signed [CW-1:0] line_s4, sample_s4;
	logic                 clip_s4;

	logic [OW-1:0]        ny_neg, nx_neg;
	logic [DW-1:0]        dsum_y, dsum_x;
	logic [UW-1:0]        usum_y, usum_x;
	logic signed [NW-1:0] ddy, ddx, udy, udx, y3, x3;
	logic signed [NW-1:0] ny_c, nx_c;
	logic signed [TW-1:0] ty, tx, hy, hx;
	logic                 cy_hi, cy_lo, cx_hi, cx_lo;

	// Stage 1 magnitudes.
	assign ny_neg = -in_item.y;
	assign nx_neg = -in_item.x;

	// Stage 3: rounded products and the new offsets.
	assign dsum_y = (DW'(dyh_s2) << GLW) + DW'(dyl_s2) + (DW'(1) << (G_FRAC-1));
	assign dsum_x = (DW'(dxh_s2) << GLW) + DW'(dxl_s2) + (DW'(1) << (G_FRAC-1));
	assign usum_y = UW'(uy_s2) + (UW'(1) << (Q_BITS-1));
	assign usum_x = UW'(ux_s2) + (UW'(1) << (Q_BITS-1));
	assign ddy    = signed'(NW'(dsum_y[G_FRAC +: MW]));
	assign ddx    = signed'(NW'(dsum_x[G_FRAC +: MW]));
	assign udy    = signed'(NW'(usum_y[Q_BITS +: MW]));
	assign udx    = signed'(NW'(usum_x[Q_BITS +: MW]));
	assign y3     = NW'(item_s2.y);
	assign x3     = NW'(item_s2.x);

	always_comb begin
		if (item_s2.cmd) begin
			ny_c = item_s2.y[OW-1] ? y3 - ddy : y3 + ddy;
			nx_c = item_s2.x[OW-1] ? x3 - ddx : x3 + ddx;
		end else if (item_s2.qone) begin
			ny_c = y3;
			nx_c = x3;
		end else begin
			ny_c = item_s2.y[OW-1] ? -udy : udy;
			nx_c = item_s2.x[OW-1] ? -udx : udx;
		end
	end

	// Stage 4: axis added back, halved in summation mode, saturated.
	assign ty = TW'(ny_s3) + signed'(TW'({axis_line, FRAC_BITS'(0)}));
	assign tx = TW'(nx_s3) + signed'(TW'({axis_sample, FRAC_BITS'(0)}));
	assign hy = summation_mode ? (ty + TW'(1)) >>> 1 : ty;
	assign hx = summation_mode ? (tx + TW'(1)) >>> 1 : tx;
	assign cy_hi = hy > T_MAX;
	assign cy_lo = hy < T_MIN;
	assign cx_hi = hx > T_MAX;
	assign cx_lo = hx < T_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		q_s1    <= in_q;
		ay_s1   <= in_item.y[OW-1] ? ny_neg[MW-1:0] : in_item.y[MW-1:0];
		ax_s1   <= in_item.x[OW-1] ? nx_neg[MW-1:0] : in_item.x[MW-1:0];

		item_s2 <= item_s1;
		dyl_s2  <= ay_s1 * item_s1.g[GLW-1:0];
		dyh_s2  <= ay_s1 * item_s1.g[GW-1:GLW];
		dxl_s2  <= ax_s1 * item_s1.g[GLW-1:0];
		dxh_s2  <= ax_s1 * item_s1.g[GW-1:GLW];
		uy_s2   <= ay_s1 * q_s1;
		ux_s2   <= ax_s1 * q_s1;

		ny_s3   <= ny_c;
		nx_s3   <= nx_c;

		line_s4   <= cy_hi ? T_MAX[CW-1:0] : (cy_lo ? T_MIN[CW-1:0] : hy[CW-1:0]);
		sample_s4 <= cx_hi ? T_MAX[CW-1:0] : (cx_lo ? T_MIN[CW-1:0] : hx[CW-1:0]);
		clip_s4   <= cy_hi | cy_lo | cx_hi | cx_lo;
	end

	assign out_valid  = vld_q[4];
	assign line_out   = line_s4;
	assign sample_out = sample_s4;
	assign clipped    = clip_s4;

endmodule

### rtl/core/radial_lens_distortion_map_top.sv
// ----------------------------------------------------------------------------
// Radial lens distortion map
// Pipeline: an accepted word passes 6 front end stages, 32 root cells of
// 4 stages each and 4 back end stages, then is strobed on the result ports.
// Throughput: one word per cycle; busy stays low and results cannot be held.
// Reset clears all valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
module radial_lens_distortion_map_top import rlm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic signed [CW-1:0] line_in,
	input  logic signed [CW-1:0] sample_in,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CIW-1:0]       cfg_index,
	input  logic [AXW-1:0]       cfg_data,
	output logic                 result_valid,
	output logic signed [CW-1:0] line_out,
	output logic signed [CW-1:0] sample_out,
	output logic                 clipped
);

	logic           summation_q;
	logic [AXW-1:0] axis_line_q, axis_sample_q;

	logic           front_valid;
	item_t          front_item;
	logic [Q_BITS:0] chain_vld;
	item_t          chain_item [0:Q_BITS];
	solve_t         chain_sol  [0:Q_BITS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summation_q   <= 1'b0;
			axis_line_q   <= AXIS_RESET;
			axis_sample_q <= AXIS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SUMMATION:   summation_q   <= cfg_data[0];
				REG_AXIS_LINE:   axis_line_q   <= cfg_data;
				REG_AXIS_SAMPLE: axis_sample_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rlm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.cmd            (cmd),
		.line_in        (line_in),
		.sample_in      (sample_in),
		.summation_mode (summation_q),
		.axis_line      (axis_line_q),
		.axis_sample    (axis_sample_q),
		.out_valid      (front_valid),
		.out_item       (front_item)
	);

	// Root solver chain, most significant bit of q first.
	assign chain_vld[0]     = front_valid;
	assign chain_item[0]    = front_item;
	assign chain_sol[0].q   = '0;
	assign chain_sol[0].q2  = '0;

	for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
		rlm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_idx   (QIW'(Q_BITS - 1 - i)),
			.in_valid  (chain_vld[i]),
			.in_item   (chain_item[i]),
			.in_sol    (chain_sol[i]),
			.out_valid (chain_vld[i+1]),
			.out_item  (chain_item[i+1]),
			.out_sol   (chain_sol[i+1])
		);
	end

	rlm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (chain_vld[Q_BITS]),
		.in_item        (chain_item[Q_BITS]),
		.in_q           (chain_sol[Q_BITS].q),
		.summation_mode (summation_q),
		.axis_line      (axis_line_q),
		.axis_sample    (axis_sample_q),
		.out_valid      (result_valid),
		.line_out       (line_out),
		.sample_out     (sample_out),
		.clipped        (clipped)
	);

	// The front end valid is the accepted-word strobe delayed through its pipeline.
	a_front_latency: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid == $past(start && !busy, 6))
		else $error("front end valid out of step with accepted words");

	// The result strobe is the root chain valid delayed through the back end.
	a_back_latency: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid == $past(chain_vld[Q_BITS], 4))
		else $error("result strobe out of step with root chain");

	// A clipped result sits on one of the range limits.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && clipped) |->
		(line_out == {1'b0, {(CW-1){1'b1}}} || line_out == {1'b1, {(CW-1){1'b0}}} ||
		sample_out == {1'b0, {(CW-1){1'b1}}} || sample_out == {1'b1, {(CW-1){1'b0}}}))
		else $error("clipped raised without a saturated coordinate");

endmodule
